/* rtl/cld_pkg.sv */
package cld_pkg;

    typedef logic [7:0] byte_t;

    localparam int LENGTH_BITS_DEFAULT = 24;

    // Header text "Content-Length: " that opens every message.
    localparam int HDR_LEN  = 16;
    localparam int HDR_POSW = $clog2(HDR_LEN);

    localparam byte_t HDR_TEXT [HDR_LEN] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    localparam byte_t CHAR_ZERO  = 8'h30;
    localparam byte_t CHAR_NINE  = 8'h39;
    localparam byte_t CHAR_SPACE = 8'h20;
    localparam byte_t CHAR_TAB   = 8'h09;
    localparam byte_t CHAR_CR    = 8'h0D;

    // Space, tab, LF, VT, FF and CR.
    function automatic logic is_ws(input byte_t c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic logic is_digit(input byte_t c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

/* rtl/content_length_deframer_core.sv */
// Channel   Ports                                 Beat carries
// input     s_valid s_ready s_in_byte             one byte of the framed stream
// result    m_valid m_ready m_payload_byte        one body byte and its
//           m_is_last                             end-of-body flag
//
// One byte is accepted per cycle; all decoding is done in the same cycle as
// the accept and the body byte appears in the output register in the next cycle.
// The output register sets the rate: a new byte is taken whenever that
// register is empty or is being drained in the same cycle.
// Reset (aresetn low at a clock edge) returns the decoder to header hunting.
// A stall on m_ready holds the result and stops input only while it lasts.
module content_length_deframer_core #(
    parameter int LENGTH_BITS = cld_pkg::LENGTH_BITS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cld_pkg::byte_t s_in_byte,
    output logic           m_valid,
    input  logic           m_ready,
    output cld_pkg::byte_t m_payload_byte,
    output logic           m_is_last
);
    import cld_pkg::*;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    localparam int LB = LENGTH_BITS;

    phase_t                phase_reg, phase_next;
    logic [HDR_POSW-1:0]   prefix_pos_reg, prefix_pos_next;
    logic [LB-1:0]         length_value_reg, length_value_next;
    logic                  length_started_reg, length_started_next;
    logic                  digits_ended_reg, digits_ended_next;
    logic [LB-1:0]         body_count_reg, body_count_next;

    logic                  m_valid_reg;
    byte_t                 m_payload_byte_reg;
    logic                  m_is_last_reg;

    logic                  accept;
    logic                  out_fire;
    logic                  out_last;
    logic [LB+3:0]         len_wide;
    logic [LB-1:0]         len_sat;
    logic [LB-1:0]         count_inc;

    assign s_ready        = !m_valid_reg || m_ready;
    assign accept         = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_payload_byte = m_payload_byte_reg;
    assign m_is_last      = m_is_last_reg;

    // length * 10 + digit, saturated to the all-ones value.
    assign len_wide  = ({4'b0, length_value_reg} << 3) + ({4'b0, length_value_reg} << 1)
                     + {{LB{1'b0}}, 4'(s_in_byte - CHAR_ZERO)};
    assign len_sat   = (len_wide[LB+3:LB] != 4'd0) ? {LB{1'b1}} : len_wide[LB-1:0];
    assign count_inc = body_count_reg + LB'(1);

    always_comb begin
        phase_next          = phase_reg;
        prefix_pos_next     = prefix_pos_reg;
        length_value_next   = length_value_reg;
        length_started_next = length_started_reg;
        digits_ended_next   = digits_ended_reg;
        body_count_next     = body_count_reg;
        out_fire            = 1'b0;
        out_last            = 1'b0;

        if (accept) begin
            unique case (phase_reg)
                PH_HUNT: begin
                    // A mismatch restarts the match without retesting this byte.
                    if (s_in_byte == HDR_TEXT[prefix_pos_reg]) begin
                        if (prefix_pos_reg == HDR_POSW'(HDR_LEN - 1)) begin
                            prefix_pos_next     = '0;
                            phase_next          = PH_LENGTH;
                            length_value_next   = '0;
                            length_started_next = 1'b0;
                            digits_ended_next   = 1'b0;
                        end else begin
                            prefix_pos_next = prefix_pos_reg + HDR_POSW'(1);
                        end
                    end else begin
                        prefix_pos_next = '0;
                    end
                end
                PH_LENGTH: begin
                    if (!length_started_reg && is_ws(s_in_byte)) begin
                        phase_next = PH_LENGTH;
                    end else if (is_ws(s_in_byte)) begin
                        phase_next          = PH_BODY;
                        body_count_next     = '0;
                        length_started_next = 1'b0;
                        digits_ended_next   = 1'b0;
                    end else begin
                        length_started_next = 1'b1;
                        if (!digits_ended_reg) begin
                            if (is_digit(s_in_byte)) begin
                                length_value_next = len_sat;
                            end else begin
                                digits_ended_next = 1'b1;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    // Whitespace ahead of the first body byte is dropped.
                    if (!(body_count_reg == '0 && is_ws(s_in_byte))) begin
                        out_fire = 1'b1;
                        // A wrapped count also ends the body; length 0 ends it on the first byte.
                        if (count_inc >= length_value_reg || count_inc == '0) begin
                            out_last        = 1'b1;
                            phase_next      = PH_HUNT;
                            prefix_pos_next = '0;
                            body_count_next = '0;
                        end else begin
                            body_count_next = count_inc;
                        end
                    end
                end
                default: begin
                    phase_next      = PH_HUNT;
                    prefix_pos_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= PH_HUNT;
            prefix_pos_reg     <= '0;
            length_value_reg   <= '0;
            length_started_reg <= 1'b0;
            digits_ended_reg   <= 1'b0;
            body_count_reg     <= '0;
            m_valid_reg        <= 1'b0;
        end else begin
            phase_reg          <= phase_next;
            prefix_pos_reg     <= prefix_pos_next;
            length_value_reg   <= length_value_next;
            length_started_reg <= length_started_next;
            digits_ended_reg   <= digits_ended_next;
            body_count_reg     <= body_count_next;
            if (accept) begin
                m_valid_reg <= out_fire;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && out_fire) begin
            m_payload_byte_reg <= s_in_byte;
            m_is_last_reg      <= out_last;
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cld_pkg::*;

    localparam int LEN_BITS = LENGTH_BITS_DEFAULT;
    localparam longint unsigned LEN_MAX = (64'd1 << LEN_BITS) - 64'd1;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int STREAM_BYTES = 800;
    localparam int DRAIN_CYCLES = 8;

    typedef logic [LEN_BITS-1:0] len_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2,
        PH_SPARE  = 2'd3
    } phase_e;

    typedef struct packed {
        byte_t data;
        logic  last;
    } body_beat_t;

    // Tracks the decoder state and holds the body beats still owed by the block.
    class deframer_scoreboard;
        phase_e      phase;
        int unsigned match_pos;
        len_t        declared_len;
        bit          len_started;
        bit          digits_done;
        len_t        body_seen;
        body_beat_t  pending[$];
        int unsigned mismatches;
        int unsigned bytes_in;
        int unsigned beats_out;
        int unsigned bodies_done;

        function new();
            phase        = PH_HUNT;
            match_pos    = 0;
            declared_len = '0;
            len_started  = 1'b0;
            digits_done  = 1'b0;
            body_seen    = '0;
            mismatches   = 0;
            bytes_in     = 0;
            beats_out    = 0;
            bodies_done  = 0;
        endfunction

        function bit is_blank(byte_t c);
            return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
        endfunction

        function void note_input(byte_t c);
            body_beat_t      beat;
            longint unsigned acc;
            bytes_in++;
            case (phase)
                PH_HUNT: begin
                    // A mismatching byte is not compared again with the first character.
                    if (match_pos < HDR_LEN && c == HDR_TEXT[match_pos])
                        match_pos++;
                    else
                        match_pos = 0;
                    if (match_pos >= HDR_LEN) begin
                        match_pos    = 0;
                        phase        = PH_LENGTH;
                        declared_len = '0;
                        len_started  = 1'b0;
                        digits_done  = 1'b0;
                    end
                end
                PH_LENGTH: begin
                    if (len_started || !is_blank(c)) begin
                        len_started = 1'b1;
                        if (is_blank(c)) begin
                            phase       = PH_BODY;
                            body_seen   = '0;
                            len_started = 1'b0;
                            digits_done = 1'b0;
                        end else if (!digits_done) begin
                            if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
                                acc = declared_len;
                                acc = acc * 10 + (c - CHAR_ZERO);
                                declared_len = (acc > LEN_MAX) ? len_t'(LEN_MAX) : len_t'(acc);
                            end else begin
                                digits_done = 1'b1;
                            end
                        end
                    end
                end
                PH_BODY: begin
                    if (body_seen != '0 || !is_blank(c)) begin
                        body_seen = body_seen + 1'b1;
                        beat.data = c;
                        beat.last = (body_seen >= declared_len) || (body_seen == '0);
                        if (beat.last) begin
                            phase     = PH_HUNT;
                            match_pos = 0;
                            body_seen = '0;
                        end
                        pending.push_back(beat);
                    end
                end
                default: begin
                    phase     = PH_HUNT;
                    match_pos = 0;
                end
            endcase
        endfunction

        function void check_result(byte_t data, logic last);
            body_beat_t exp_beat;
            beats_out++;
            if (pending.size() == 0) begin
                $error("unexpected body beat: payload_byte %0h is_last %0b", data, last);
                mismatches++;
                return;
            end
            exp_beat = pending.pop_front();
            if (data !== exp_beat.data) begin
                $error("payload_byte mismatch: expected %0h, actual %0h", exp_beat.data, data);
                mismatches++;
            end
            if (last !== exp_beat.last) begin
                $error("is_last mismatch: expected %0b, actual %0b", exp_beat.last, last);
                mismatches++;
            end
            if (last === 1'b1)
                bodies_done++;
        endfunction
    endclass

    logic  aclk      = 1'b0;
    logic  aresetn   = 1'b0;
    logic  s_valid   = 1'b0;
    logic  s_ready;
    byte_t s_in_byte = '0;
    logic  m_valid;
    logic  m_ready   = 1'b0;
    byte_t m_payload_byte;
    logic  m_is_last;

    deframer_scoreboard sb;
    byte_t       stim_q[$];
    bit          calm       = 1'b0;
    int unsigned calm_left  = 100;
    int unsigned sink_wait  = 0;
    int unsigned cycle_count = 0;

    content_length_deframer_core #(
        .LENGTH_BITS(LEN_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_payload_byte(m_payload_byte),
        .m_is_last     (m_is_last)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one; none during a calm stretch.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    always @(posedge aclk) begin
        if (calm_left == 0) begin
            calm      <= ~calm;
            calm_left <= calm ? $urandom_range(100, 400) : $urandom_range(50, 150);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    always @(negedge aclk) begin
        if (sink_wait > 0) begin
            m_ready   <= 1'b0;
            sink_wait <= sink_wait - 1;
        end else begin
            m_ready   <= 1'b1;
            sink_wait <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_payload_byte, m_is_last);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    function automatic bit blank_char(byte_t c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic byte_t pick_blank();
        int unsigned r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CHAR_SPACE : byte_t'(r);
    endfunction

    // Neither whitespace nor a digit.
    function automatic byte_t pick_junk();
        byte_t c;
        do
            c = byte_t'($urandom_range(0, 255));
        while (blank_char(c) || (c >= CHAR_ZERO && c <= CHAR_NINE));
        return c;
    endfunction

    function automatic byte_t pick_body_start();
        byte_t c;
        do
            c = byte_t'($urandom_range(0, 255));
        while (blank_char(c));
        return c;
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            stim_q.push_back(byte_t'(s[i]));
    endtask

    task automatic push_header();
        for (int i = 0; i < HDR_LEN; i++)
            stim_q.push_back(HDR_TEXT[i]);
    endtask

    task automatic push_noise(int unsigned n);
        repeat (n) stim_q.push_back(byte_t'($urandom_range(0, 255)));
    endtask

    // One framed message, sometimes damaged, or a run of line noise.
    task automatic add_random_unit();
        int unsigned kind;
        int unsigned len;
        int unsigned n;
        byte_t       b;
        kind = $urandom_range(0, 99);
        if (kind < 10) begin
            push_noise($urandom_range(1, 20));
        end else begin
            if ($urandom_range(0, 3) == 0)
                push_noise($urandom_range(1, 6));
            if ($urandom_range(0, 6) == 0) begin
                n = $urandom_range(1, HDR_LEN - 1);
                for (int i = 0; i < n; i++)
                    stim_q.push_back(HDR_TEXT[i]);
                if ($urandom_range(0, 1) == 0) begin
                    b = HDR_TEXT[0];
                end else begin
                    do
                        b = pick_junk();
                    while (b == HDR_TEXT[n]);
                end
                stim_q.push_back(b);
            end
            push_header();
            repeat ($urandom_range(0, 2)) stim_q.push_back(pick_blank());
            if (kind < 20) begin
                // No leading digit, so the declared length is zero.
                case ($urandom_range(0, 2))
                    0: push_text("+");
                    1: push_text("-");
                    default: stim_q.push_back(pick_junk());
                endcase
                if ($urandom_range(0, 1) == 0)
                    push_text($sformatf("%0d", $urandom_range(1, 99)));
                len = 0;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60)
                                                  : $urandom_range(0, 12);
                if ($urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) stim_q.push_back(CHAR_ZERO);
                push_text($sformatf("%0d", len));
                if ($urandom_range(0, 6) == 0) begin
                    stim_q.push_back(pick_junk());
                    push_text("7");
                end
            end
            stim_q.push_back(pick_blank());
            repeat ($urandom_range(0, 2)) stim_q.push_back(pick_blank());
            n = (len == 0) ? 1 : len;
            if (kind >= 92)
                n = $urandom_range(0, n);
            for (int i = 0; i < n; i++) begin
                if (i == 0 && kind < 92)
                    stim_q.push_back(pick_body_start());
                else
                    stim_q.push_back(byte_t'($urandom_range(0, 255)));
            end
        end
    endtask

    // Entered and left at a falling edge; the byte is noted when its beat is taken.
    task automatic send_byte(byte_t b);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_in_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_input(b);
        @(negedge aclk);
    endtask

    initial begin
        sb = new();

        // Zero length still passes one byte, here the lowest value.
        push_text("Content-Length: 0 ");
        stim_q.push_back(8'h00);
        // Whitespace ahead of the length and ahead of the body.
        push_text("Content-Length: \t 3\r\n\r\n");
        stim_q.push_back(8'hFF);
        push_text("a");
        stim_q.push_back(8'h80);
        // Sign character ends the digits at once.
        push_text("Content-Length: -5 Z");
        // Digits stop at the letter; the trailing 9 is ignored.
        push_text("Content-Length: 2x9 qr");
        // A doubled first letter loses the header.
        push_text("CContent-Length: 1 k");
        // Vertical tab ends the length, form feed is skipped before the body.
        push_text("Content-Length: 1");
        stim_q.push_back(8'h0B);
        stim_q.push_back(8'h0C);
        push_text("m");

        while (stim_q.size() < STREAM_BYTES)
            add_random_unit();

        // A saturated length never completes, so it goes last.
        push_text("Content-Length: 99999999999 xyz");
        stim_q.push_back(8'h00);
        stim_q.push_back(8'hFF);

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (stim_q[i])
            send_byte(stim_q[i]);
        s_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d stream bytes, checked %0d body beats and %0d complete bodies",
                 sb.bytes_in, sb.beats_out, sb.bodies_done);
        $display("stream had noise, broken headers, odd length fields and a saturated length");
        if (sb.mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
